### sv/far_pkg.sv
// ----------------------------------------------------------------------------
// far_pkg
// Shared types for the fraction add-and-reduce core: sequencer states,
// datapath operation codes and the control and status bundles.
// ----------------------------------------------------------------------------
package far_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_ADD,
        S_SWAP,
        S_TWOS,
        S_GCD,
        S_SCALE,
        S_DIVN,
        S_DIVD,
        S_FIN
    } state_t;

    // Datapath operation issued each cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_ADD,
        OP_SWAP,
        OP_TWOS,
        OP_GCD,
        OP_SCALE,
        OP_DIVN,
        OP_DIVD
    } op_t;

    // Sequencer to datapath and top level
    typedef struct packed {
        op_t  op;
        logic in_ready;
        logic out_load;
    } ctrl_t;

    // Datapath flags back to the sequencer
    typedef struct packed {
        logic zero_den;
        logic add_swap;
        logic add_zero;
        logic both_even;
        logic x_zero;
        logic cnt_last;
    } stat_t;

endpackage

### sv/far_datapath.sv
// ----------------------------------------------------------------------------
// far_datapath
// Operand registers, one shared multiplier and one shared add/subtract unit.
// The unit forms the cross sum, runs the binary GCD and both restoring
// divisions, one step per cycle under the sequencer's operation code.
// ----------------------------------------------------------------------------
module far_datapath #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                         clk,
    input  far_pkg::ctrl_t               ctl,
    input  logic [OPERAND_WIDTH-1:0]     a_num,
    input  logic [OPERAND_WIDTH-1:0]     a_den,
    input  logic [OPERAND_WIDTH-1:0]     b_num,
    input  logic [OPERAND_WIDTH-1:0]     b_den,
    output far_pkg::stat_t               stat,
    output logic [2*OPERAND_WIDTH-1:0]   num_mag,
    output logic [2*OPERAND_WIDTH-1:0]   den_mag,
    output logic                         num_neg,
    output logic                         zero_den_error
);
    import far_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(PW);

    logic [W-1:0]  an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic          an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [PW-1:0] p1_reg, p2_reg, nm_reg, den_reg, x_reg, y_reg;
    logic [CW-1:0] k_reg, cnt_reg;
    logic          ns_reg, err_reg;

    logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
    logic          in_zero;
    logic          s1, s2, ds;
    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] prod;
    logic [PW-1:0] au_a, au_b;
    logic          au_sub;
    logic [PW:0]   au_res;
    logic          borrow;
    logic [PW-1:0] div_q, div_shift;

    // Split incoming operands into magnitudes
    always_comb
    begin
        an_mag  = a_num[W-1] ? (~a_num + W'(1)) : a_num;
        ad_mag  = a_den[W-1] ? (~a_den + W'(1)) : a_den;
        bn_mag  = b_num[W-1] ? (~b_num + W'(1)) : b_num;
        bd_mag  = b_den[W-1] ? (~b_den + W'(1)) : b_den;
        in_zero = (a_den == '0) || (b_den == '0);
    end

    // Signs of the two cross products and of the denominator
    assign s1 = an_neg_reg ^ bd_neg_reg;
    assign s2 = ad_neg_reg ^ bn_neg_reg;
    assign ds = ad_neg_reg ^ bd_neg_reg;

    // Shared multiplier operand select
    always_comb
    begin
        case (ctl.op)
            OP_MUL1:
            begin
                mul_a = an_mag_reg;
                mul_b = bd_mag_reg;
            end
            OP_MUL2:
            begin
                mul_a = ad_mag_reg;
                mul_b = bn_mag_reg;
            end
            default:
            begin
                mul_a = ad_mag_reg;
                mul_b = bd_mag_reg;
            end
        endcase
    end

    assign prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

    // Division step: shift the next dividend bit into the remainder
    assign div_q     = (ctl.op == OP_DIVD) ? den_reg : nm_reg;
    assign div_shift = {x_reg[PW-2:0], div_q[PW-1]};

    // Shared add/subtract unit operand select
    always_comb
    begin
        case (ctl.op)
            OP_ADD:
            begin
                au_a   = p1_reg;
                au_b   = p2_reg;
                au_sub = s1 ^ s2;
            end
            OP_SWAP:
            begin
                au_a   = p2_reg;
                au_b   = p1_reg;
                au_sub = 1'b1;
            end
            OP_DIVN, OP_DIVD:
            begin
                au_a   = div_shift;
                au_b   = y_reg;
                au_sub = 1'b1;
            end
            default:
            begin
                au_a   = x_reg;
                au_b   = y_reg;
                au_sub = 1'b1;
            end
        endcase
    end

    assign au_res = au_sub ? ({1'b0, au_a} - {1'b0, au_b})
                           : ({1'b0, au_a} + {1'b0, au_b});
    assign borrow = au_res[PW];

    // Flags for the sequencer
    always_comb
    begin
        stat.zero_den  = in_zero;
        stat.add_swap  = (s1 ^ s2) && borrow;
        stat.add_zero  = (au_res[PW-1:0] == '0);
        stat.both_even = !x_reg[0] && !y_reg[0];
        stat.x_zero    = (x_reg == '0);
        stat.cnt_last  = (cnt_reg == CW'(PW - 1));
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LOAD:
            begin
                an_mag_reg <= an_mag;
                ad_mag_reg <= ad_mag;
                bn_mag_reg <= bn_mag;
                bd_mag_reg <= bd_mag;
                an_neg_reg <= a_num[W-1];
                ad_neg_reg <= a_den[W-1];
                bn_neg_reg <= b_num[W-1];
                bd_neg_reg <= b_den[W-1];
                err_reg    <= in_zero;
                if (in_zero)
                begin
                    nm_reg  <= '0;
                    den_reg <= PW'(1);
                    ns_reg  <= 1'b0;
                end
            end
            OP_MUL1: p1_reg  <= prod;
            OP_MUL2: p2_reg  <= prod;
            OP_MUL3: den_reg <= prod;
            OP_ADD:
            begin
                x_reg <= au_res[PW-1:0];
                y_reg <= den_reg;
                k_reg <= '0;
                if (!stat.add_swap)
                begin
                    nm_reg <= au_res[PW-1:0];
                    if (stat.add_zero)
                    begin
                        den_reg <= PW'(1);
                        ns_reg  <= 1'b0;
                    end
                    else
                    begin
                        ns_reg <= s1 ^ ds;
                    end
                end
            end
            OP_SWAP:
            begin
                x_reg  <= au_res[PW-1:0];
                nm_reg <= au_res[PW-1:0];
                ns_reg <= s2 ^ ds;
            end
            OP_TWOS:
            begin
                // strip common factors of two
                if (stat.both_even)
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + CW'(1);
                end
            end
            OP_GCD:
            begin
                if (stat.x_zero)
                begin
                    x_reg <= x_reg;
                end
                else if (!x_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_reg <= y_reg >> 1;
                end
                else if (!borrow)
                begin
                    x_reg <= au_res[PW-1:0];
                end
                else
                begin
                    x_reg <= y_reg;
                    y_reg <= x_reg;
                end
            end
            OP_SCALE:
            begin
                // restore the common power of two
                y_reg   <= y_reg << k_reg;
                x_reg   <= '0;
                cnt_reg <= '0;
            end
            OP_DIVN, OP_DIVD:
            begin
                if (stat.cnt_last)
                begin
                    x_reg   <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    x_reg   <= borrow ? div_shift : au_res[PW-1:0];
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (ctl.op == OP_DIVN)
                begin
                    nm_reg <= {nm_reg[PW-2:0], !borrow};
                end
                else
                begin
                    den_reg <= {den_reg[PW-2:0], !borrow};
                end
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign num_mag        = nm_reg;
    assign den_mag        = den_reg;
    assign num_neg        = ns_reg;
    assign zero_den_error = err_reg;

endmodule

### sv/far_ctrl.sv
// ----------------------------------------------------------------------------
// far_ctrl
// Sequencer: steps the datapath through multiply, sum, GCD and the two
// divisions, then hands the result to the output register.
// ----------------------------------------------------------------------------
module far_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           out_free,
    input  far_pkg::stat_t stat,
    output far_pkg::ctrl_t ctl
);
    import far_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.zero_den ? S_FIN : S_MUL1;
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_MUL3;
            S_MUL3: state_next = S_ADD;
            S_ADD:
            begin
                if (stat.add_swap)
                begin
                    state_next = S_SWAP;
                end
                else
                begin
                    state_next = stat.add_zero ? S_FIN : S_TWOS;
                end
            end
            S_SWAP: state_next = S_TWOS;
            S_TWOS:
            begin
                if (!stat.both_even)
                begin
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (stat.x_zero)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE: state_next = S_DIVN;
            S_DIVN:
            begin
                if (stat.cnt_last)
                begin
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (stat.cnt_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl.op       = OP_NONE;
        ctl.in_ready = 1'b0;
        ctl.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ctl.in_ready = 1'b1;
                ctl.op       = in_valid ? OP_LOAD : OP_NONE;
            end
            S_MUL1:  ctl.op = OP_MUL1;
            S_MUL2:  ctl.op = OP_MUL2;
            S_MUL3:  ctl.op = OP_MUL3;
            S_ADD:   ctl.op = OP_ADD;
            S_SWAP:  ctl.op = OP_SWAP;
            S_TWOS:  ctl.op = OP_TWOS;
            S_GCD:   ctl.op = OP_GCD;
            S_SCALE: ctl.op = OP_SCALE;
            S_DIVN:  ctl.op = OP_DIVN;
            S_DIVD:  ctl.op = OP_DIVD;
            S_FIN:   ctl.out_load = out_free;
            default: ctl.op = OP_NONE;
        endcase
    end

endmodule

### sv/fraction_add_reduce_core.sv
// ----------------------------------------------------------------------------
// fraction_add_reduce_core
// Adds two signed fractions and returns the sum in lowest terms.
//
//   channel   dir  beat contents (lowest bits first)
//   s_axis    in   tdata: a_num, a_den, b_num, b_den
//   m_axis    out  tdata: sum_num, sum_den   tuser: zero_den_error
//
// A beat runs three multiplies, the binary GCD loop on the shared add/subtract
// unit (data dependent) and two 2*W-step restoring divisions, W = OPERAND_WIDTH.
// A zero denominator goes straight to the finish step and a zero sum skips the
// GCD loop and both divisions.
// s_axis is taken only while idle; a finished result waits in the output
// register and a stalled m_axis holds the sequencer at its last step.
// Reset clears the sequencer and the output valid flag only.
// ----------------------------------------------------------------------------
module fraction_add_reduce_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // a_num, a_den, b_num, b_den
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // sum_num, sum_den
    output logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    // zero_den_error
    output logic                                   m_axis_tuser
);
    import far_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int NW = 2 * OPERAND_WIDTH + 1;
    localparam int DW = 2 * OPERAND_WIDTH - 1;

    ctrl_t         ctl;
    stat_t         stat;
    logic [PW-1:0] num_mag, den_mag;
    logic          num_neg, dp_err;
    logic          out_free;
    logic [NW-1:0] num_signed;

    logic          out_valid_reg, out_valid_next;
    logic [NW-1:0] out_num_reg;
    logic [DW-1:0] out_den_reg;
    logic          out_err_reg;

    far_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .ctl      (ctl)
    );

    far_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .ctl            (ctl),
        .a_num          (s_axis_tdata[W-1:0]),
        .a_den          (s_axis_tdata[2*W-1:W]),
        .b_num          (s_axis_tdata[3*W-1:2*W]),
        .b_den          (s_axis_tdata[4*W-1:3*W]),
        .stat           (stat),
        .num_mag        (num_mag),
        .den_mag        (den_mag),
        .num_neg        (num_neg),
        .zero_den_error (dp_err)
    );

    assign s_axis_tready = ctl.in_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Apply the sign to the reduced numerator
    assign num_signed = num_neg ? (NW'(0) - {1'b0, num_mag}) : {1'b0, num_mag};

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result beat
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_num_reg <= num_signed;
            out_den_reg <= den_mag[DW-1:0];
            out_err_reg <= dp_err;
        end
    end

    // Pack the result beat
    always_comb
    begin
        m_axis_tdata               = '0;
        m_axis_tdata[NW-1:0]       = out_num_reg;
        m_axis_tdata[NW+DW-1:NW]   = out_den_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_err_reg;

`ifndef SYNTHESIS
    // The sequencer never takes a beat while it hands one over
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.in_ready && ctl.out_load))
        else $error("input accepted while loading the output register");

    // One beat at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready straight after an accepted beat");

    // An error result reads 0/1
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (out_num_reg == '0 && out_den_reg == DW'(1)))
        else $error("zero denominator result is not 0/1");

    // A reduced denominator is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_den_reg != '0))
        else $error("zero denominator in result");
`endif

endmodule

### tb/fraction_add_reduce_core_test.sv
// ----------------------------------------------------------------------------
// fraction_add_reduce_core_test
// Self-checking bench for the fraction add-and-reduce core. Fraction pairs go
// in on s_axis; a behavioural predictor works out each reduced sum in 64-bit
// sign-magnitude arithmetic, and every m_axis beat is compared field by field
// against the oldest prediction. Directed corner cases come first, then
// random pairs under several idling mixes, then a long output hold-off that
// backs the core up into its input.
// ----------------------------------------------------------------------------
module fraction_add_reduce_core_test;

    localparam int W      = 16;
    localparam int NUM_W  = 2 * W + 1;
    localparam int DEN_W  = 2 * W - 1;
    localparam int DATA_W = ((4 * W + 7) / 8) * 8;

    // Reduced sum as it leaves the core
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             zero_den;
    } fraction_sum_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // a_num, a_den, b_num, b_den
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // sum_num, sum_den
    logic [DATA_W-1:0] m_axis_tdata;
    // zero_den_error
    logic              m_axis_tuser;

    fraction_sum_t     pending_sums[$];
    int                error_count = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_request = 0;
    int                hold_left = 0;

    fraction_add_reduce_core #(
        .OPERAND_WIDTH (W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Magnitude of a two's complement operand, exact for the most negative value
    function automatic longint unsigned operand_magnitude(input logic [W-1:0] v);
        logic [W-1:0] m;
        m = v[W-1] ? (~v + W'(1)) : v;
        return 64'(m);
    endfunction

    // Cross-multiply, add, move the sign up and divide out the GCD
    function automatic fraction_sum_t sum_in_lowest_terms(input logic [W-1:0] an_raw,
                                                          input logic [W-1:0] ad_raw,
                                                          input logic [W-1:0] bn_raw,
                                                          input logic [W-1:0] bd_raw);
        fraction_sum_t     r;
        longint unsigned   an, ad, bn, bd, m1, m2, nm, dm, x, y, t;
        logic              s1, s2, ns;
        an = operand_magnitude(an_raw);
        ad = operand_magnitude(ad_raw);
        bn = operand_magnitude(bn_raw);
        bd = operand_magnitude(bd_raw);
        if (ad == 0 || bd == 0)
        begin
            r.num      = '0;
            r.den      = DEN_W'(1);
            r.zero_den = 1'b1;
            return r;
        end
        m1 = an * bd;
        s1 = an_raw[W-1] ^ bd_raw[W-1];
        m2 = ad * bn;
        s2 = ad_raw[W-1] ^ bn_raw[W-1];
        if (s1 == s2)
        begin
            nm = m1 + m2;
            ns = s1;
        end
        else if (m1 >= m2)
        begin
            nm = m1 - m2;
            ns = s1;
        end
        else
        begin
            nm = m2 - m1;
            ns = s2;
        end
        dm = ad * bd;
        ns = ns ^ ad_raw[W-1] ^ bd_raw[W-1];
        if (nm == 0)
            ns = 1'b0;
        x = nm;
        y = dm;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        nm = nm / x;
        dm = dm / x;
        nm = ns ? (64'd0 - nm) : nm;
        r.num      = nm[NUM_W-1:0];
        r.den      = dm[DEN_W-1:0];
        r.zero_den = 1'b0;
        return r;
    endfunction

    // Offer one fraction pair, with random idle cycles ahead of it
    task automatic send_fractions(input logic [W-1:0] an, input logic [W-1:0] ad,
                                  input logic [W-1:0] bn, input logic [W-1:0] bd);
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bd, bn, ad, an};
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            if (taken)
                pending_sums.push_back(sum_in_lowest_terms(an, ad, bn, bd));
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Offer one fraction pair given as plain integers
    task automatic send_values(input int an, input int ad, input int bn, input int bd);
        send_fractions(W'(an), W'(ad), W'(bn), W'(bd));
    endtask

    // Drive the output ready: honour a hold-off first, else stall at random
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left      = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check each output beat against the oldest prediction
    always @(negedge clk)
    begin
        fraction_sum_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_sums.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected beat: num %0h den %0h err %0b",
                             m_axis_tdata[NUM_W-1:0], m_axis_tdata[NUM_W+DEN_W-1:NUM_W],
                             m_axis_tuser);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (m_axis_tdata[NUM_W-1:0] !== want.num ||
                    m_axis_tdata[NUM_W+DEN_W-1:NUM_W] !== want.den ||
                    m_axis_tuser !== want.zero_den)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: exp %0h/%0h err %0b, act %0h/%0h err %0b",
                                 want.num, want.den, want.zero_den,
                                 m_axis_tdata[NUM_W-1:0],
                                 m_axis_tdata[NUM_W+DEN_W-1:NUM_W], m_axis_tuser);
                end
            end
        end
    end

    // Operand drawn from full range, small values, extremes or powers of two
    function automatic logic [W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return W'($urandom);
            5, 6, 7:       return W'($urandom_range(0, 40)) - W'(20);
            8:             return $urandom_range(0, 1) ? {1'b1, {(W-1){1'b0}}}
                                                       : {1'b0, {(W-1){1'b1}}};
            default:       return W'(1) << $urandom_range(0, W - 1);
        endcase
    endfunction

    // Corner cases: extremes, signs, zero sum, zero denominators
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_values(1, 2, 1, 3);
        send_values(1, 2, -1, 2);
        send_values(0, 5, 0, -7);
        send_values(1, -2, 1, -3);
        send_values(-1, -2, 1, 3);
        send_values(32767, 32767, 32767, 32767);
        send_values(-32768, 1, -32768, 1);
        send_values(-32768, -32768, -32768, -32768);
        send_values(32767, -32768, -32768, 32767);
        send_values(1, 32767, 1, -32768);
        send_values(-32768, 32767, -32768, 32767);
        send_values(32767, 1, 32767, -32768);
        send_values(-32768, -32768, -32768, 1);
        send_values(5, 0, 1, 2);
        send_values(1, 2, 3, 0);
        send_values(0, 0, 0, 0);
        send_values(-32768, 0, 32767, -32768);
        send_values(6, 4, 3, 2);
        send_values(0, 1, 7, -1);
        send_values(2, 4, 2, 4);
        send_values(0, -32768, -32768, -32768);
        send_values(-1, -1, -1, -1);
    endtask

    // Random pairs under one idling mix
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        logic [W-1:0] an, ad, bn, bd;
        int           pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            an   = random_operand();
            ad   = random_operand();
            bn   = random_operand();
            bd   = random_operand();
            pick = $urandom_range(0, 99);
            if (pick < 4)
                ad = '0;
            else if (pick < 8)
                bd = '0;
            else if (pick < 14)
            begin
                // force a zero sum
                bn = ~an + W'(1);
                bd = ad;
            end
            send_fractions(an, ad, bn, bd);
        end
    endtask

    // Hold the output off for a long stretch while input keeps coming
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 2000;
        for (int i = 0; i < 4; i++)
            send_fractions(random_operand(), random_operand() | W'(1),
                           random_operand(), random_operand() | W'(1));
    endtask

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Sequence the tests
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(225, 0, 0);
        test_random(225, 59, 0);
        test_random(225, 0, 59);
        test_random(225, 33, 33);
        test_backpressure();
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0 && pending_sums.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
